>>> sv/skt_pkg.sv
// Shared types and constants for the sorted knot table.
package skt_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int KEY_W         = 32;
  localparam int POS_W         = 6;
  localparam int RIDX_W        = 6;
  localparam int CNT_W         = 7;
  localparam int REQ_W         = 3;

  typedef enum logic [2:0] {
    REQ_INSERT   = 3'd0,
    REQ_DEL_KEY  = 3'd1,
    REQ_DEL_POS  = 3'd2,
    REQ_MOVE_POS = 3'd3,
    REQ_MOVE_KEY = 3'd4,
    REQ_FIND     = 3'd5,
    REQ_READ     = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RGN_EMPTY  = 2'd0,
    RGN_BELOW  = 2'd1,
    RGN_INSIDE = 2'd2,
    RGN_ABOVE  = 2'd3
  } region_e;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_CMP,
    CELL_DROP,
    CELL_PLACE,
    CELL_SETVAL
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MCMP,
    ST_MEVAL
  } state_e;

  typedef struct packed {
    cell_op_e                 op;
    logic                     by_key;
    logic signed [KEY_W-1:0]  key;
    logic signed [KEY_W-1:0]  value;
    logic [POS_W-1:0]         pos;
  } cell_cmd_t;

  typedef struct packed {
    logic any_lt;
    logic any_sel;
  } skt_hit_t;

endpackage

>>> sv/sorted_knot_table_core.sv
// Sorted knot table: a chain of key/value cells run by a small sequencer.
//
//   port group   direction  handshake               beat contents
//   in_*         input      in_valid_i / in_stall_o  one request
//   out_*        output     out_valid_o / out_stall_i one result
//
// A request starts with a compare broadcast to all cells at the accepting edge; the
// evaluation step then reduces the flags and applies the shift or write.
// A move that finds its knot removes it, compares again and then places the knot,
// so it has an extra compare after removing the knot.
// The result register lets a new request enter while a result is stalled;
// the final step of the next request waits for that register to empty.
// Reset clears the count, control state and cell flags; cell keys and values need no clearing.
module sorted_knot_table_core
  import skt_pkg::*;
#(
  parameter int MaxKnots = MAX_KNOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [KEY_W-1:0]  match_key_i,
  input  logic signed [KEY_W-1:0]  knot_key_i,
  input  logic signed [KEY_W-1:0]  knot_value_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic                     replace_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [RIDX_W-1:0]        result_index_o,
  output logic [CNT_W-1:0]         knot_count_o,
  output logic [1:0]               region_o,
  output logic signed [KEY_W-1:0]  read_key_o,
  output logic signed [KEY_W-1:0]  read_value_o
);

  localparam int IW = (MaxKnots > 1) ? $clog2(MaxKnots) : 1;
  localparam int CW = $clog2(MaxKnots + 1);

  state_e                  state_q, state_d;
  logic [REQ_W-1:0]        req_q;
  logic signed [KEY_W-1:0] kkey_q, kval_q;
  logic                    repl_q;
  logic [CW-1:0]           count_q, count_d;
  logic signed [KEY_W-1:0] old_key_q, old_val_q;
  logic [IW-1:0]           drop_idx_q;
  logic                    save_old;

  logic                    out_valid_q;
  logic [1:0]              status_q;
  logic [RIDX_W-1:0]       ridx_q;
  logic [CW-1:0]           ocount_q;
  logic [1:0]              region_q;
  logic signed [KEY_W-1:0] rkey_q, rval_q;

  logic                    out_wr;
  logic                    out_free;
  logic                    in_acc;
  status_e                 res_status;
  logic [CW-1:0]           res_idx;
  region_e                 res_region;
  logic signed [KEY_W-1:0] res_key, res_val;

  cell_cmd_t               cmd;
  logic [IW-1:0]           cmd_idx;

  logic signed [KEY_W-1:0] cell_key [MaxKnots];
  logic signed [KEY_W-1:0] cell_val [MaxKnots];
  logic signed [KEY_W-1:0] cell_rk  [MaxKnots];
  logic signed [KEY_W-1:0] cell_rv  [MaxKnots];
  logic [MaxKnots-1:0]     cell_lt;
  logic [MaxKnots-1:0]     cell_last;
  logic [MaxKnots-1:0]     cell_sel;

  skt_hit_t                hit;
  logic [IW-1:0]           lt_idx, sel_idx;
  logic signed [KEY_W-1:0] sel_key, sel_val;
  logic [CW-1:0]           below;
  logic [CW-1:0]           seg;

  for (genvar g = 0; g < MaxKnots; g++) begin : g_cell
    logic signed [KEY_W-1:0] lk, lv, rk, rv;
    logic                    rlt;
    if (g == 0) begin : g_first
      assign lk = '0;
      assign lv = '0;
    end else begin : g_mid
      assign lk = cell_key[g-1];
      assign lv = cell_val[g-1];
    end
    if (g == MaxKnots - 1) begin : g_last
      assign rk  = '0;
      assign rv  = '0;
      assign rlt = 1'b0;
    end else begin : g_inner
      assign rk  = cell_key[g+1];
      assign rv  = cell_val[g+1];
      assign rlt = cell_lt[g+1];
    end
    skt_cell #(
      .Idx (g),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .cmd_idx_i   (cmd_idx),
      .count_i     (count_q),
      .left_key_i  (lk),
      .left_val_i  (lv),
      .right_key_i (rk),
      .right_val_i (rv),
      .right_lt_i  (rlt),
      .key_o       (cell_key[g]),
      .val_o       (cell_val[g]),
      .lt_o        (cell_lt[g]),
      .last_lt_o   (cell_last[g]),
      .sel_o       (cell_sel[g]),
      .rd_key_o    (cell_rk[g]),
      .rd_val_o    (cell_rv[g])
    );
  end

  skt_reduce #(
    .N  (MaxKnots),
    .IW (IW)
  ) u_reduce (
    .last_lt_i (cell_last),
    .sel_i     (cell_sel),
    .rd_key_i  (cell_rk),
    .rd_val_i  (cell_rv),
    .hit_o     (hit),
    .lt_idx_o  (lt_idx),
    .sel_idx_o (sel_idx),
    .rd_key_o  (sel_key),
    .rd_val_o  (sel_val)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign below      = hit.any_lt ? CW'(CW'(lt_idx) + CW'(1)) : '0;

  always_comb begin
    seg = (below == '0) ? '0 : CW'(below - CW'(1));
    if (count_q < CW'(2)) begin
      seg = '0;
    end else if (seg > CW'(count_q - CW'(2))) begin
      seg = CW'(count_q - CW'(2));
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    save_old     = 1'b0;
    out_wr       = 1'b0;
    res_status   = STAT_REJECT;
    res_idx      = '0;
    res_region   = RGN_EMPTY;
    res_key      = '0;
    res_val      = '0;
    cmd.op       = CELL_NOP;
    cmd.by_key   = 1'b1;
    cmd.key      = kkey_q;
    cmd.value    = kval_q;
    cmd.pos      = position_i;
    cmd_idx      = sel_idx;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.op     = CELL_CMP;
          cmd.by_key = !(req_type_i == REQ_DEL_POS || req_type_i == REQ_MOVE_POS ||
                         req_type_i == REQ_READ);
          cmd.key    = (req_type_i == REQ_INSERT) ? knot_key_i : match_key_i;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if ((req_q == REQ_MOVE_POS || req_q == REQ_MOVE_KEY) && hit.any_sel) begin
          cmd.op   = CELL_DROP;
          count_d  = CW'(count_q - CW'(1));
          save_old = 1'b1;
          state_d  = ST_MCMP;
        end else if (out_free) begin
          out_wr  = 1'b1;
          state_d = ST_IDLE;
          unique case (req_q)
            REQ_INSERT: begin
              if (hit.any_sel) begin
                if (repl_q) begin
                  cmd.op     = CELL_SETVAL;
                  res_status = STAT_OK;
                  res_idx    = CW'(sel_idx);
                end
              end else if (count_q == CW'(MaxKnots)) begin
                res_status = STAT_FULL;
              end else begin
                cmd.op     = CELL_PLACE;
                cmd_idx    = IW'(below);
                count_d    = CW'(count_q + CW'(1));
                res_status = STAT_OK;
                res_idx    = below;
              end
            end
            REQ_DEL_KEY, REQ_DEL_POS: begin
              if (hit.any_sel) begin
                cmd.op     = CELL_DROP;
                count_d    = CW'(count_q - CW'(1));
                res_status = STAT_OK;
                res_idx    = CW'(sel_idx);
              end
            end
            REQ_FIND: begin
              res_status = STAT_OK;
              if (count_q != '0) begin
                res_idx = seg;
                if (!hit.any_lt && !hit.any_sel) begin
                  res_region = RGN_BELOW;
                end else if (below == count_q) begin
                  res_region = RGN_ABOVE;
                end else begin
                  res_region = RGN_INSIDE;
                end
              end
            end
            REQ_READ: begin
              if (hit.any_sel) begin
                res_status = STAT_OK;
                res_idx    = CW'(sel_idx);
                res_key    = sel_key;
                res_val    = sel_val;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MCMP: begin
        cmd.op  = CELL_CMP;
        state_d = ST_MEVAL;
      end
      ST_MEVAL: begin
        if (out_free) begin
          out_wr  = 1'b1;
          state_d = ST_IDLE;
          cmd.op  = CELL_PLACE;
          count_d = CW'(count_q + CW'(1));
          if (hit.any_sel) begin
            cmd.key    = old_key_q;
            cmd.value  = old_val_q;
            cmd_idx    = drop_idx_q;
          end else begin
            cmd_idx    = IW'(below);
            res_status = STAT_OK;
            res_idx    = below;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      req_q       <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (in_acc) begin
        req_q <= req_type_i;
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kkey_q <= knot_key_i;
      kval_q <= knot_value_i;
      repl_q <= replace_i;
    end
    if (save_old) begin
      old_key_q  <= sel_key;
      old_val_q  <= sel_val;
      drop_idx_q <= sel_idx;
    end
    if (out_wr) begin
      status_q <= res_status;
      ridx_q   <= RIDX_W'(res_idx);
      ocount_q <= count_d;
      region_q <= res_region;
      rkey_q   <= res_key;
      rval_q   <= res_val;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_index_o = ridx_q;
  assign knot_count_o   = CNT_W'(ocount_q);
  assign region_o       = region_q;
  assign read_key_o     = rkey_q;
  assign read_value_o   = rval_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxKnots))
    else $error("knot count exceeds table size");

  a_accept_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_EVAL)
    else $error("accepted request did not enter evaluation");

  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_MEVAL))
    else $error("result appeared outside an evaluation step");

  a_count_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_MEVAL))
    else $error("knot count changed outside an evaluation step");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STAT_FULL) |-> ocount_q == CW'(MaxKnots))
    else $error("full status reported on a table that is not full");

endmodule

>>> sv/skt_cell.sv
// One table slot: holds a knot, compares it and shifts it along the chain.
module skt_cell
  import skt_pkg::*;
#(
  parameter int Idx = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_cmd_t               cmd_i,
  input  logic [IW-1:0]           cmd_idx_i,
  input  logic [CW-1:0]           count_i,
  input  logic signed [KEY_W-1:0] left_key_i,
  input  logic signed [KEY_W-1:0] left_val_i,
  input  logic signed [KEY_W-1:0] right_key_i,
  input  logic signed [KEY_W-1:0] right_val_i,
  input  logic                    right_lt_i,
  output logic signed [KEY_W-1:0] key_o,
  output logic signed [KEY_W-1:0] val_o,
  output logic                    lt_o,
  output logic                    last_lt_o,
  output logic                    sel_o,
  output logic signed [KEY_W-1:0] rd_key_o,
  output logic signed [KEY_W-1:0] rd_val_o
);

  localparam int PW = (IW > POS_W) ? IW : POS_W;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [KEY_W-1:0] val_q, val_d;
  logic                    lt_q, lt_d;
  logic                    sel_q, sel_d;
  logic                    occ;
  logic                    pos_hit;
  logic                    at_idx;
  logic                    past_idx;

  assign occ      = CW'(Idx) < count_i;
  assign pos_hit  = PW'(cmd_i.pos) == PW'(Idx);
  assign at_idx   = cmd_idx_i == IW'(Idx);
  assign past_idx = IW'(Idx) > cmd_idx_i;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    lt_d  = lt_q;
    sel_d = sel_q;
    unique case (cmd_i.op)
      CELL_CMP: begin
        lt_d  = occ && (key_q < cmd_i.key);
        sel_d = occ && (cmd_i.by_key ? (key_q == cmd_i.key) : pos_hit);
      end
      CELL_DROP: begin
        if (at_idx || past_idx) begin
          key_d = right_key_i;
          val_d = right_val_i;
        end
      end
      CELL_PLACE: begin
        if (at_idx) begin
          key_d = cmd_i.key;
          val_d = cmd_i.value;
        end else if (past_idx) begin
          key_d = left_key_i;
          val_d = left_val_i;
        end
      end
      CELL_SETVAL: begin
        if (at_idx) begin
          val_d = cmd_i.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      lt_q  <= lt_d;
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign key_o     = key_q;
  assign val_o     = val_q;
  assign lt_o      = lt_q;
  assign last_lt_o = lt_q && !right_lt_i;
  assign sel_o     = sel_q;
  assign rd_key_o  = sel_q ? key_q : '0;
  assign rd_val_o  = sel_q ? val_q : '0;

endmodule

>>> sv/skt_reduce.sv
// Collects the cell flags into indexes and selected knot data.
module skt_reduce
  import skt_pkg::*;
#(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  logic [N-1:0]            last_lt_i,
  input  logic [N-1:0]            sel_i,
  input  logic signed [KEY_W-1:0] rd_key_i [N],
  input  logic signed [KEY_W-1:0] rd_val_i [N],
  output skt_hit_t                hit_o,
  output logic [IW-1:0]           lt_idx_o,
  output logic [IW-1:0]           sel_idx_o,
  output logic signed [KEY_W-1:0] rd_key_o,
  output logic signed [KEY_W-1:0] rd_val_o
);

  always_comb begin
    lt_idx_o  = '0;
    sel_idx_o = '0;
    rd_key_o  = '0;
    rd_val_o  = '0;
    for (int i = 0; i < N; i++) begin
      if (last_lt_i[i]) begin
        lt_idx_o = lt_idx_o | IW'(i);
      end
      if (sel_i[i]) begin
        sel_idx_o = sel_idx_o | IW'(i);
      end
      rd_key_o = rd_key_o | rd_key_i[i];
      rd_val_o = rd_val_o | rd_val_i[i];
    end
    hit_o.any_lt  = |last_lt_i;
    hit_o.any_sel = |sel_i;
  end

endmodule
